>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion wrappers used by the checker file uft_check.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off while reset is low
`define UFT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed (same cycle)");

// next-cycle implication, held off while reset is low
`define UFT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed (next cycle)");

`endif

>>> rtl/uft_pkg.sv
// ----------------------------------------------------------------------------
// uft_pkg
// Beat types, function codes and balance helpers for the union-find engine.
// ----------------------------------------------------------------------------
package uft_pkg;

	// function codes of an input beat
	localparam logic [1:0] FUNC_LEFT  = 2'd0;
	localparam logic [1:0] FUNC_RIGHT = 2'd1;
	localparam logic [1:0] FUNC_EDGE  = 2'd2;

	localparam logic signed [12:0] BAL_MAX = 13'sd2047;
	localparam logic signed [12:0] BAL_MIN = -13'sd2048;

	localparam logic [62:0] TOTAL_MAX = {63{1'b1}};

	typedef struct packed {
		logic [1:0]  func;
		logic [9:0]  vertex_a;
		logic [9:0]  vertex_b;
		logic [29:0] weight;
	} uft_item_t;

	typedef struct packed {
		logic [62:0] total;
		logic        joined;
		logic [10:0] pairs_matched;
	} uft_result_t;

	// merge unit control and status
	typedef struct packed {
		logic start;
	} uft_merge_ctl_t;

	typedef struct packed {
		logic busy;
	} uft_merge_stat_t;

	// store status
	typedef struct packed {
		logic clearing;
	} uft_store_stat_t;

	// clamp a widened balance back into 12 signed bits
	function automatic logic signed [11:0] sat_bal(input logic signed [12:0] x);
		logic signed [11:0] r;
		if (x > BAL_MAX) begin
			r = 12'sh7FF;
		end else if (x < BAL_MIN) begin
			r = 12'sh800;
		end else begin
			r = x[11:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/uft_store.sv
// ----------------------------------------------------------------------------
// uft_store
// Vertex memory: parent link, token balance and component size per vertex.
// One synchronous read port (registered read data), one write port, and a
// clearing sweep after reset that makes every vertex its own root.
// ----------------------------------------------------------------------------
module uft_store #(
	parameter int VERTEX_COUNT = 1024,
	parameter int VW           = 10,
	parameter int SW           = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   rd_en,
	input  logic [VW-1:0]          rd_addr,
	output logic [VW-1:0]          rd_parent,
	output logic signed [11:0]     rd_bal,
	output logic [SW-1:0]          rd_size,
	input  logic                   wr_en,
	input  logic [VW-1:0]          wr_addr,
	input  logic [VW-1:0]          wr_parent,
	input  logic signed [11:0]     wr_bal,
	input  logic [SW-1:0]          wr_size,
	output uft_pkg::uft_store_stat_t stat
);
	import uft_pkg::*;

	typedef struct packed {
		logic [VW-1:0]      parent;
		logic signed [11:0] bal;
		logic [SW-1:0]      size;
	} entry_t;

	localparam logic [VW-1:0] LAST_ADDR = VW'(VERTEX_COUNT - 1);

	entry_t        mem [VERTEX_COUNT];
	entry_t        rd_data_q;
	logic          clr_busy_q;
	logic [VW-1:0] clr_addr_q;

	// clearing sweep, one entry a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// write port, sweep has priority
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '{parent: clr_addr_q, bal: 12'sd0, size: SW'(1)};
		end else if (wr_en) begin
			mem[wr_addr] <= '{parent: wr_parent, bal: wr_bal, size: wr_size};
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_parent     = rd_data_q.parent;
	assign rd_bal        = rd_data_q.bal;
	assign rd_size       = rd_data_q.size;
	assign stat.clearing = clr_busy_q;

endmodule

>>> rtl/uft_merge.sv
// ----------------------------------------------------------------------------
// uft_merge
// Pair count, weight product and saturating running total, three stages.
// ----------------------------------------------------------------------------
module uft_merge (
	input  logic                     clk,
	input  logic                     arst_n,
	input  uft_pkg::uft_merge_ctl_t  ctl,
	input  logic signed [11:0]       bal_a,
	input  logic signed [11:0]       bal_b,
	input  logic [31:0]              weight,
	output logic [62:0]              total,
	output logic [10:0]              pairs,
	output uft_pkg::uft_merge_stat_t stat
);
	import uft_pkg::*;

	logic        opposite;
	logic [11:0] mag_a;
	logic [11:0] mag_b;
	logic [11:0] min_mag;
	logic [63:0] sum;

	logic        v_s1;
	logic        v_s2;
	logic [10:0] pairs_s1;
	logic [31:0] w_s1;
	logic [42:0] prod_s2;
	logic [62:0] total_q;

	// pairs cancelled when the balances have opposite signs
	always_comb begin
		opposite = ((bal_a > 12'sd0) && (bal_b < 12'sd0)) ||
			((bal_a < 12'sd0) && (bal_b > 12'sd0));
		mag_a    = bal_a[11] ? 12'(-bal_a) : 12'(bal_a);
		mag_b    = bal_b[11] ? 12'(-bal_b) : 12'(bal_b);
		min_mag  = (mag_a < mag_b) ? mag_a : mag_b;
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= ctl.start;
			v_s2 <= v_s1;
		end
	end

	// stage 1: pair count, held for the result beat
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			pairs_s1 <= opposite ? min_mag[10:0] : 11'd0;
			w_s1     <= weight;
		end
	end

	// stage 2: weight times pairs
	always_ff @(posedge clk) begin
		if (v_s1) begin
			prod_s2 <= 43'(w_s1 * pairs_s1);
		end
	end

	// stage 3: saturating accumulate
	assign sum = {1'b0, total_q} + 64'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (v_s2) begin
			total_q <= sum[63] ? TOTAL_MAX : sum[62:0];
		end
	end

	assign total     = total_q;
	assign pairs     = pairs_s1;
	assign stat.busy = v_s1 | v_s2;

endmodule

>>> rtl/union_find_token_matching.sv
// ----------------------------------------------------------------------------
// union_find_token_matching
// Union-find engine pairing left and right tokens across joined components.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                   | payload
//  ---------+-----+-----------------------------+--------------------------
//  item     | in  | item_valid / item_ready     | uft_item_t (func, vertices)
//  result   | out | result_valid / result_ready | uft_result_t (total, pairs)
//
//  One item at a time. A token walks from its vertex to its root, an
//  edge from both of its vertices (one memory read a cycle, the depth
//  of a walk at most log2(VERTEX_COUNT) with union by size). After
//  reset a clearing sweep over all VERTEX_COUNT entries runs before the
//  first item is taken. A stalled result sits in the output register while
//  the next item is already taken in.
// ----------------------------------------------------------------------------
module union_find_token_matching #(
	parameter int VERTEX_COUNT = 1024,
	parameter int WEIGHT_BITS  = 30
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  uft_pkg::uft_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output uft_pkg::uft_result_t result
);
	import uft_pkg::*;

	localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int SW = $clog2(VERTEX_COUNT + 1);
	localparam logic [31:0] WMASK = 32'((64'd1 << WEIGHT_BITS) - 64'd1);

	// sequencer states
	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_FIND_A = 3'd1;
	localparam logic [2:0] ST_FIND_B = 3'd2;
	localparam logic [2:0] ST_TOKW   = 3'd3;
	localparam logic [2:0] ST_JOIN1  = 3'd4;
	localparam logic [2:0] ST_JOIN2  = 3'd5;
	localparam logic [2:0] ST_WAIT   = 3'd6;
	localparam logic [2:0] ST_RESP   = 3'd7;

	logic [2:0]         state_q;
	logic [2:0]         state_d;
	logic [1:0]         func_q;
	logic [VW-1:0]      vb_q;
	logic [31:0]        weight_q;
	logic [VW-1:0]      cur_q;
	logic [VW-1:0]      root_a_q;
	logic signed [11:0] bal_a_q;
	logic [SW-1:0]      size_a_q;
	logic [VW-1:0]      root_b_q;
	logic signed [11:0] bal_b_q;
	logic [SW-1:0]      size_b_q;
	logic               joined_q;
	logic               result_valid_q;
	uft_result_t        result_q;

	logic               rd_en;
	logic [VW-1:0]      rd_addr;
	logic [VW-1:0]      rd_parent;
	logic signed [11:0] rd_bal;
	logic [SW-1:0]      rd_size;
	logic               wr_en;
	logic [VW-1:0]      wr_addr;
	logic [VW-1:0]      wr_parent;
	logic signed [11:0] wr_bal;
	logic [SW-1:0]      wr_size;
	uft_store_stat_t    store_stat;

	uft_merge_ctl_t     merge_ctl;
	uft_merge_stat_t    merge_stat;
	logic [62:0]        merge_total;
	logic [10:0]        merge_pairs;

	logic               accept;
	logic               va_ok;
	logic               vb_ok;
	logic               is_token;
	logic               is_edge;
	logic               at_root;
	logic               a_small;
	logic               out_free;
	logic signed [12:0] tok_delta;

	uft_store #(
		.VERTEX_COUNT(VERTEX_COUNT),
		.VW(VW),
		.SW(SW)
	) u_store (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_parent(rd_parent),
		.rd_bal(rd_bal),
		.rd_size(rd_size),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_parent(wr_parent),
		.wr_bal(wr_bal),
		.wr_size(wr_size),
		.stat(store_stat)
	);

	uft_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(merge_ctl),
		.bal_a(bal_a_q),
		.bal_b(bal_b_q),
		.weight(weight_q),
		.total(merge_total),
		.pairs(merge_pairs),
		.stat(merge_stat)
	);

	// input decode
	assign item_ready = (state_q == ST_IDLE) && !store_stat.clearing;
	assign accept     = item_valid && item_ready;
	assign va_ok      = 32'(item.vertex_a) < 32'(VERTEX_COUNT);
	assign vb_ok      = 32'(item.vertex_b) < 32'(VERTEX_COUNT);
	assign is_token   = ((item.func == FUNC_LEFT) || (item.func == FUNC_RIGHT)) && va_ok;
	assign is_edge    = (item.func == FUNC_EDGE) && va_ok && vb_ok;
	assign at_root    = (rd_parent == cur_q);
	assign a_small    = size_a_q < size_b_q;
	assign out_free   = !result_valid_q || result_ready;
	assign tok_delta  = (func_q == FUNC_LEFT) ? 13'sd1 : -13'sd1;

	// sequencer: memory ports and next state
	always_comb begin
		state_d         = state_q;
		rd_en           = 1'b0;
		rd_addr         = cur_q;
		wr_en           = 1'b0;
		wr_addr         = root_a_q;
		wr_parent       = root_a_q;
		wr_bal          = bal_a_q;
		wr_size         = size_a_q;
		merge_ctl.start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_addr = VW'(item.vertex_a);
					if (is_token || is_edge) begin
						rd_en   = 1'b1;
						state_d = ST_FIND_A;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_FIND_A: begin
				if (at_root) begin
					if (func_q == FUNC_EDGE) begin
						rd_en   = 1'b1;
						rd_addr = vb_q;
						state_d = ST_FIND_B;
					end else begin
						state_d = ST_TOKW;
					end
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_parent;
				end
			end
			ST_FIND_B: begin
				if (at_root) begin
					state_d = (cur_q == root_a_q) ? ST_RESP : ST_JOIN1;
				end else begin
					rd_en   = 1'b1;
					rd_addr = rd_parent;
				end
			end
			ST_TOKW: begin
				wr_en   = 1'b1;
				wr_bal  = sat_bal({bal_a_q[11], bal_a_q} + tok_delta);
				state_d = ST_RESP;
			end
			ST_JOIN1: begin
				// hang the smaller root under the larger, tie goes under a
				wr_en           = 1'b1;
				merge_ctl.start = 1'b1;
				wr_addr         = a_small ? root_a_q : root_b_q;
				wr_parent       = a_small ? root_b_q : root_a_q;
				wr_bal          = a_small ? bal_a_q : bal_b_q;
				wr_size         = a_small ? size_a_q : size_b_q;
				state_d         = ST_JOIN2;
			end
			ST_JOIN2: begin
				wr_en     = 1'b1;
				wr_addr   = a_small ? root_b_q : root_a_q;
				wr_parent = a_small ? root_b_q : root_a_q;
				wr_bal    = sat_bal({bal_a_q[11], bal_a_q} + {bal_b_q[11], bal_b_q});
				wr_size   = size_a_q + size_b_q;
				state_d   = ST_WAIT;
			end
			ST_WAIT: begin
				if (!merge_stat.busy) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			joined_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				joined_q <= 1'b0;
			end else if ((state_q == ST_FIND_B) && at_root && (cur_q != root_a_q)) begin
				joined_q <= 1'b1;
			end
			if ((state_q == ST_RESP) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// item and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= item.func;
			vb_q     <= VW'(item.vertex_b);
			weight_q <= 32'(item.weight) & WMASK;
			cur_q    <= VW'(item.vertex_a);
		end else if (rd_en) begin
			cur_q <= rd_addr;
		end
		if ((state_q == ST_FIND_A) && at_root) begin
			root_a_q <= cur_q;
			bal_a_q  <= rd_bal;
			size_a_q <= rd_size;
		end
		if ((state_q == ST_FIND_B) && at_root) begin
			root_b_q <= cur_q;
			bal_b_q  <= rd_bal;
			size_b_q <= rd_size;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if ((state_q == ST_RESP) && out_free) begin
			result_q.total         <= merge_total;
			result_q.joined        <= joined_q;
			result_q.pairs_matched <= joined_q ? merge_pairs : 11'd0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> rtl/uft_check.sv
// ----------------------------------------------------------------------------
// uft_check
// Port-level checks for the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uft_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 item_valid,
	input logic                 item_ready,
	input logic                 result_valid,
	input logic                 result_ready,
	input uft_pkg::uft_result_t result
);
	import uft_pkg::*;

	// one item in flight: no second beat right after a taken one
	`UFT_ASSERT_NEXT(a_one_in_flight, clk, arst_n, item_valid && item_ready, !item_ready)

	// no pairs reported without a join
	`UFT_ASSERT_NOW(a_pairs_need_join, clk, arst_n, result_valid && !result.joined, result.pairs_matched == 11'd0)

	// a stalled result beat holds
	`UFT_ASSERT_NEXT(a_result_holds, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind union_find_token_matching uft_check u_check (
	.clk(clk),
	.arst_n(arst_n),
	.item_valid(item_valid),
	.item_ready(item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result(result)
);
